FILE: rtl/core/kpt_pkg.sv
package kpt_pkg;

  localparam int TIME_BITS  = 32;
  localparam int FRAME_BITS = 20;
  localparam int FPS_BITS   = 8;
  localparam int RATIO_BITS = 17;
  localparam int SPEED_BITS = 16;
  localparam int DELTA_BITS = 16;
  // Dividend width covers (first + offset) << 16 and elapsed << 16.
  localparam int DIV_BITS   = TIME_BITS + 17;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

  localparam logic [TIME_BITS-1:0]  FINISH_EPS = TIME_BITS'(66);
  localparam logic [SPEED_BITS-1:0] SPEED_ONE  = SPEED_BITS'(256);
  localparam logic [RATIO_BITS-1:0] RATIO_ONE  = RATIO_BITS'(65536);
  localparam logic [FPS_BITS-1:0]   FPS_RESET  = FPS_BITS'(30);
  localparam logic [FRAME_BITS-1:0] FRAME_MAX  = '1;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PLAY = 2'd1,
    CMD_SEEK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_FPS  = 1'b0,
    REG_PLAY = 1'b1
  } reg_idx_t;

  // Controller to datapath.
  typedef struct packed {
    logic start_fade_div;  // load divider with elapsed/duration
    logic start_seek_div;  // load divider with frame/fps
    logic do_tick;         // advance time or fade elapsed
    logic do_play;         // load pending clip
    logic do_fade_end;     // finish fade or compute ratio
    logic do_frames;       // compute frame outputs
    logic do_frames2;      // second step: saturate and finish
    logic do_seek_end;     // clamp seek result
  } cmd_bus_t;

  // Datapath to controller.
  typedef struct packed {
    logic fading;
    logic fade_done;   // elapsed >= duration
    logic div_busy;
  } sts_bus_t;

endpackage

FILE: rtl/core/kpt_ctrl.sv
module kpt_ctrl
  import kpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_go,
  input  logic [1:0]           in_cmd,
  input  sts_bus_t             sts,
  input  logic                 out_free,
  output logic                 busy,
  output logic                 out_load,
  output cmd_bus_t             cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_TICK  = 8'b0000_0010,
    S_FRM1  = 8'b0000_0100,
    S_FRM2  = 8'b0000_1000,
    S_FDIV  = 8'b0001_0000,
    S_SDIV  = 8'b0010_0000,
    S_FADE  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    out_load   = 1'b0;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_go) begin
          case (in_cmd)
            CMD_TICK: begin
              cmd.do_tick = 1'b1;
              state_next  = S_TICK;
            end
            CMD_PLAY: begin
              cmd.do_play = 1'b1;
              state_next  = S_OUT;
            end
            CMD_SEEK: begin
              cmd.start_seek_div = 1'b1;
              state_next = S_SDIV;
            end
            default: state_next = S_OUT;
          endcase
        end
      end
      S_TICK: begin
        if (sts.fading) begin
          if (sts.fade_done) begin
            cmd.do_fade_end = 1'b1;
            state_next = S_OUT;
          end else begin
            cmd.start_fade_div = 1'b1;
            state_next = S_FDIV;
          end
        end else begin
          cmd.do_frames = 1'b1;
          state_next = S_FRM1;
        end
      end
      S_FRM1: begin
        cmd.do_frames2 = 1'b1;
        state_next = S_FRM2;
      end
      S_FRM2: state_next = S_OUT;
      S_FDIV: begin
        if (!sts.div_busy) begin
          cmd.do_fade_end = 1'b1;
          state_next = S_OUT;
        end
      end
      S_SDIV: begin
        if (!sts.div_busy) begin
          cmd.do_seek_end = 1'b1;
          state_next = S_FADE;
        end
      end
      S_FADE: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/kpt_div.sv
module kpt_div
  import kpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [TIME_BITS-1:0] divisor,
  output logic                busy,
  output logic [DIV_BITS-1:0] quotient
);

  logic [DIV_BITS-1:0]     quo;
  logic [TIME_BITS:0]      rem;
  logic [TIME_BITS-1:0]    dvs;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [TIME_BITS:0]      trial;
  logic [TIME_BITS+1:0]    diff;

  assign trial = {rem[TIME_BITS-1:0], quo[DIV_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign quotient = quo;

  // One quotient bit per cycle, restoring.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_BITS'(DIV_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_BITS'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[TIME_BITS+1]) begin
        rem <= diff[TIME_BITS:0];
        quo <= {quo[DIV_BITS-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[DIV_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/core/kpt_dp.sv
module kpt_dp
  import kpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_bus_t              cmd,
  output sts_bus_t              sts,
  input  logic [FPS_BITS-1:0]   fps,
  input  logic                  play_en,
  input  logic [DELTA_BITS-1:0] delta_time,
  input  logic [SPEED_BITS-1:0] speed,
  input  logic [31:0]           fade_duration,
  input  logic [31:0]           clip_start_time,
  input  logic [31:0]           clip_length,
  input  logic [19:0]           clip_first_frame,
  input  logic [19:0]           clip_last_frame,
  input  logic                  repeat_flag,
  input  logic                  reverse_flag,
  input  logic [19:0]           seek_frame,
  output logic [FRAME_BITS-1:0] frame_q,
  output logic [FRAME_BITS-1:0] next_q,
  output logic [RATIO_BITS-1:0] ratio_q,
  output logic                  fading_q,
  output logic                  finished_c
);

  typedef struct packed {
    logic [TIME_BITS-1:0]  start;
    logic [TIME_BITS-1:0]  length;
    logic [FRAME_BITS-1:0] first;
    logic [FRAME_BITS-1:0] last;
    logic                  rpt;
    logic                  rev;
    logic [SPEED_BITS-1:0] speed;
  } clip_t;

  localparam clip_t CLIP_RESET = '{start: '0, length: '0, first: '0, last: '0,
                                   rpt: 1'b1, rev: 1'b0, speed: SPEED_ONE};

  clip_t cur, pend;
  logic [TIME_BITS-1:0]  clip_time, elapsed, dur;
  logic [TIME_BITS+FPS_BITS:0] pos;
  logic                  div_busy;
  logic [DIV_BITS-1:0]   div_q, div_a;
  logic [TIME_BITS-1:0]  div_b;
  logic                  div_start;
  logic [FPS_BITS-1:0]   efps;
  logic [DELTA_BITS+SPEED_BITS-9:0] step;
  logic [TIME_BITS:0]    sum, esum;
  logic [TIME_BITS+FPS_BITS-16:0] frm_raw;
  logic [FRAME_BITS-1:0] frm;
  logic [15:0]           frac;
  logic [TIME_BITS-1:0]  span;
  logic [DIV_BITS-1:0]   tgt;
  logic [DIV_BITS-1:0]   seek_num;
  logic [FRAME_BITS:0]   ff_sum;

  function automatic logic [TIME_BITS-1:0] sat32(input logic [31:0] v);
    sat32 = (TIME_BITS >= 32) ? TIME_BITS'(v) :
            ((v >> TIME_BITS) != 0 ? '1 : TIME_BITS'(v));
  endfunction

  assign efps = (fps == '0) ? FPS_BITS'(1) : fps;
  assign step = (DELTA_BITS+SPEED_BITS-8)'((32'(delta_time) * 32'(cur.speed)) >> 8);
  assign sum  = {1'b0, clip_time} + (TIME_BITS+1)'(step);
  assign esum = {1'b0, elapsed} + (TIME_BITS+1)'(step);

  assign ff_sum   = {1'b0, cur.first} + {1'b0, seek_frame};
  assign seek_num = DIV_BITS'(ff_sum) << 16;

  assign div_start = cmd.start_fade_div | cmd.start_seek_div;
  assign div_a = cmd.start_fade_div ? (DIV_BITS'(elapsed) << 16) : seek_num;
  assign div_b = cmd.start_fade_div ? dur : TIME_BITS'(efps);

  kpt_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  assign tgt = div_q - DIV_BITS'(cur.start);

  assign frm_raw = pos[TIME_BITS+FPS_BITS:16];
  assign frm  = ((frm_raw >> FRAME_BITS) != 0) ? FRAME_MAX : FRAME_BITS'(frm_raw);
  assign frac = pos[15:0];

  assign sts.fading    = fading_q;
  assign sts.fade_done = elapsed >= dur;
  assign sts.div_busy  = div_busy;

  assign span = (clip_time > cur.length) ? clip_time - cur.length
                                         : cur.length - clip_time;
  assign finished_c = !fading_q && (cur.rev ? (clip_time < FINISH_EPS)
                                            : (span < FINISH_EPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= CLIP_RESET; pend <= CLIP_RESET;
      clip_time <= '0; elapsed <= '0; dur <= '0; fading_q <= 1'b0;
      frame_q <= '0; next_q <= '0; ratio_q <= '0; pos <= '0;
    end else begin
      if (cmd.do_tick && play_en) begin
        if (fading_q) begin
          elapsed <= esum[TIME_BITS] ? '1 : esum[TIME_BITS-1:0];
        end else if (cur.rev) begin
          if (TIME_BITS'(step) >= clip_time || (step >> TIME_BITS) != 0)
            clip_time <= cur.rpt ? cur.length : '0;
          else
            clip_time <= clip_time - TIME_BITS'(step);
        end else begin
          if (sum >= {1'b0, cur.length})
            clip_time <= cur.rpt ? '0 : cur.length;
          else
            clip_time <= sum[TIME_BITS-1:0];
        end
      end
      if (cmd.do_frames)
        pos <= (TIME_BITS+FPS_BITS+1)'({1'b0, cur.start} + {1'b0, clip_time}) *
               (TIME_BITS+FPS_BITS+1)'(efps);
      if (cmd.do_frames2) begin
        frame_q <= frm;
        if (cur.rev) begin
          next_q  <= (frm <= cur.first) ? frm : frm - 1'b1;
          ratio_q <= RATIO_ONE - RATIO_BITS'(frac);
        end else begin
          next_q  <= (frm >= cur.last) ? frm : frm + 1'b1;
          ratio_q <= RATIO_BITS'(frac);
        end
      end
      if (cmd.do_fade_end) begin
        if (elapsed >= dur) begin
          cur <= pend;
          clip_time <= pend.rev ? pend.length : '0;
          pend <= CLIP_RESET;
          fading_q <= 1'b0;
          elapsed <= '0; dur <= '0;
          frame_q <= next_q;
          ratio_q <= '0;
        end else begin
          ratio_q <= RATIO_BITS'(div_q);
        end
      end
      if (cmd.do_play) begin
        pend.speed  <= speed;
        dur         <= sat32(fade_duration);
        pend.start  <= sat32(clip_start_time);
        pend.length <= sat32(clip_length);
        pend.first  <= FRAME_BITS'(clip_first_frame);
        pend.last   <= FRAME_BITS'(clip_last_frame);
        pend.rpt    <= repeat_flag;
        pend.rev    <= reverse_flag;
        elapsed     <= '0;
        fading_q    <= 1'b1;
        next_q      <= reverse_flag ? FRAME_BITS'(clip_last_frame)
                                    : FRAME_BITS'(clip_first_frame);
      end
      if (cmd.do_seek_end) begin
        if (div_q <= DIV_BITS'(cur.start))
          clip_time <= '0;
        else if (tgt > DIV_BITS'(cur.length))
          clip_time <= cur.length;
        else
          clip_time <= TIME_BITS'(tgt);
      end
    end
  end

endmodule

FILE: rtl/core/keyframe_playback_timer.sv
// Channel  | Direction | Handshake           | Payload
// input    | in        | in_valid / in_stall | command .. seek_frame
// result   | out       | out_valid/out_stall | frame_index .. finished
// config   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item at a time. Play and the unused code go straight to S_OUT; a tick
// without a fade passes S_TICK, S_FRM1 and S_FRM2, a tick that ends a fade
// S_TICK, a tick mid-fade S_TICK and S_FDIV, and a seek S_SDIV and S_FADE,
// before S_OUT loads the result. The shared restoring divider yields one
// quotient bit per cycle over 49 bits. Reset is synchronous; it restores the
// clip, fade and register defaults. The result register holds a beat while
// out_stall is high; the input is stalled until the result is loaded.
module keyframe_playback_timer
  import kpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [15:0] delta_time,
  input  logic [15:0] speed,
  input  logic [31:0] fade_duration,
  input  logic [31:0] clip_start_time,
  input  logic [31:0] clip_length,
  input  logic [19:0] clip_first_frame,
  input  logic [19:0] clip_last_frame,
  input  logic        repeat_flag,
  input  logic        reverse_flag,
  input  logic [19:0] seek_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] frame_index,
  output logic [19:0] next_frame_index,
  output logic [16:0] blend_ratio,
  output logic        fading,
  output logic        finished,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cmd_bus_t cmd;
  sts_bus_t sts;
  logic busy, out_load, in_go, out_free;
  logic [FPS_BITS-1:0] fps;
  logic play_en;
  logic [FRAME_BITS-1:0] frame_q, next_q;
  logic [RATIO_BITS-1:0] ratio_q;
  logic fading_q, finished_c;

  // Take an item only when the controller is idle.
  assign in_stall = busy;
  assign in_go    = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fps     <= FPS_RESET;
      play_en <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FPS:  fps     <= cfg_data;
        REG_PLAY: play_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  kpt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_go(in_go), .in_cmd(command), .sts(sts),
    .out_free(out_free), .busy(busy), .out_load(out_load), .cmd(cmd)
  );

  kpt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .fps(fps), .play_en(play_en),
    .delta_time(delta_time), .speed(speed), .fade_duration(fade_duration),
    .clip_start_time(clip_start_time), .clip_length(clip_length),
    .clip_first_frame(clip_first_frame), .clip_last_frame(clip_last_frame),
    .repeat_flag(repeat_flag), .reverse_flag(reverse_flag),
    .seek_frame(seek_frame), .frame_q(frame_q), .next_q(next_q),
    .ratio_q(ratio_q), .fading_q(fading_q), .finished_c(finished_c)
  );

  // Result register: hold the beat while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      frame_index      <= 20'(frame_q);
      next_frame_index <= 20'(next_q);
      blend_ratio      <= ratio_q;
      fading           <= fading_q;
      finished         <= finished_c;
    end
  end

endmodule

FILE: rtl/core/kpt_checker.sv
module kpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] blend_ratio,
  input logic        fading,
  input logic        finished
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(blend_ratio))
    else $error("result beat dropped under stall");

  a_fade_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid && fading |-> !finished)
    else $error("finished while fading");

  a_ratio: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> blend_ratio <= 17'd65536)
    else $error("blend ratio above one");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before result");

endmodule

bind keyframe_playback_timer kpt_checker u_kpt_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .blend_ratio(blend_ratio),
  .fading(fading), .finished(finished)
);

FILE: tb/keyframe_playback_timer_tb.sv
`timescale 1ns / 1ps

module keyframe_playback_timer_tb
  import kpt_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [15:0] delta_time;
  logic [15:0] speed;
  logic [31:0] fade_duration;
  logic [31:0] clip_start_time;
  logic [31:0] clip_length;
  logic [19:0] clip_first_frame;
  logic [19:0] clip_last_frame;
  logic        repeat_flag;
  logic        reverse_flag;
  logic [19:0] seek_frame;
  logic        out_valid;
  logic        out_stall;
  logic [19:0] frame_index;
  logic [19:0] next_frame_index;
  logic [16:0] blend_ratio;
  logic        fading;
  logic        finished;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_data;

  keyframe_playback_timer u_top (.*);

  // One input beat.
  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] delta;
    logic [15:0] spd;
    logic [31:0] fade_dur;
    logic [31:0] start;
    logic [31:0] length;
    logic [19:0] first;
    logic [19:0] last;
    logic        rep;
    logic        rev;
    logic [19:0] seek;
  } play_item_t;

  // One result beat.
  typedef struct {
    logic [19:0] frame;
    logic [19:0] next;
    logic [16:0] ratio;
    logic        fade;
    logic        done;
  } frame_report_t;

  typedef struct {
    logic [31:0] start;
    logic [31:0] length;
    logic [19:0] first;
    logic [19:0] last;
    logic        rep;
    logic        rev;
    logic [15:0] spd;
  } clip_t;

  // Predictor state mirrors the block's registers.
  logic [7:0]  m_fps;
  logic        m_play_en;
  logic [31:0] m_time;
  clip_t       m_cur;
  clip_t       m_pend;
  logic [31:0] m_elapsed;
  logic [31:0] m_dur;
  logic        m_fading;
  logic [19:0] m_frame;
  logic [19:0] m_next;
  logic [16:0] m_ratio;

  frame_report_t expected_reports[$];
  int  error_count;
  int  idle_cycles;
  bit  hold_results;
  int  hold_cycles;

  function automatic clip_t default_clip();
    clip_t c;
    c = '{default: '0};
    c.rep = 1'b1;
    c.spd = SPEED_ONE;
    return c;
  endfunction

  function automatic logic [63:0] fps_used();
    return (m_fps == 0) ? 64'd1 : 64'(m_fps);
  endfunction

  function automatic void predict_reset();
    m_fps     = FPS_RESET;
    m_play_en = 1'b1;
    m_time    = '0;
    m_cur     = default_clip();
    m_pend    = default_clip();
    m_elapsed = '0;
    m_dur     = '0;
    m_fading  = 1'b0;
    m_frame   = '0;
    m_next    = '0;
    m_ratio   = '0;
  endfunction

  // Work out the report that one beat produces and advance the model.
  function automatic frame_report_t predict_frame_report(play_item_t it);
    frame_report_t r;
    logic [63:0] step, sum, pos, fr, target, span;
    step = (64'(it.delta) * 64'(m_cur.spd)) >> 8;
    case (it.cmd)
      CMD_TICK: begin
        if (m_fading) begin
          if (m_play_en) begin
            sum = 64'(m_elapsed) + step;
            m_elapsed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
          end
          if (m_elapsed >= m_dur) begin
            m_cur     = m_pend;
            m_time    = m_cur.rev ? m_cur.length : '0;
            m_pend    = default_clip();
            m_fading  = 1'b0;
            m_elapsed = '0;
            m_dur     = '0;
            m_frame   = m_next;
            m_ratio   = '0;
          end else begin
            m_ratio = 17'((64'(m_elapsed) << 16) / 64'(m_dur));
          end
        end else begin
          if (m_play_en) begin
            if (m_cur.rev) begin
              if (step >= 64'(m_time)) m_time = m_cur.rep ? m_cur.length : '0;
              else m_time = m_time - step[31:0];
            end else begin
              sum = 64'(m_time) + step;
              if (sum >= 64'(m_cur.length)) m_time = m_cur.rep ? '0 : m_cur.length;
              else m_time = sum[31:0];
            end
          end
          pos = (64'(m_cur.start) + 64'(m_time)) * fps_used();
          fr  = pos >> 16;
          if (fr > 64'(FRAME_MAX)) fr = 64'(FRAME_MAX);
          m_frame = fr[19:0];
          if (m_cur.rev) begin
            m_next  = (m_frame <= m_cur.first) ? m_frame : m_frame - 20'd1;
            m_ratio = RATIO_ONE - 17'(pos[15:0]);
          end else begin
            m_next  = (m_frame >= m_cur.last) ? m_frame : m_frame + 20'd1;
            m_ratio = 17'(pos[15:0]);
          end
        end
      end
      CMD_PLAY: begin
        m_pend.spd    = it.spd;
        m_dur         = it.fade_dur;
        m_pend.start  = it.start;
        m_pend.length = it.length;
        m_pend.first  = it.first;
        m_pend.last   = it.last;
        m_pend.rep    = it.rep;
        m_pend.rev    = it.rev;
        m_elapsed     = '0;
        m_fading      = 1'b1;
        m_next        = it.rev ? it.last : it.first;
      end
      CMD_SEEK: begin
        target = ((64'(m_cur.first) + 64'(it.seek)) << 16) / fps_used();
        if (target <= 64'(m_cur.start)) m_time = '0;
        else if (target - 64'(m_cur.start) > 64'(m_cur.length)) m_time = m_cur.length;
        else m_time = 32'(target - 64'(m_cur.start));
      end
      default: ;
    endcase
    r.frame = m_frame;
    r.next  = m_next;
    r.ratio = m_ratio;
    r.fade  = m_fading;
    if (m_fading) r.done = 1'b0;
    else if (m_cur.rev) r.done = m_time < FINISH_EPS;
    else begin
      span = (m_time > m_cur.length) ? 64'(m_time - m_cur.length)
                                     : 64'(m_cur.length - m_time);
      r.done = span < 64'(FINISH_EPS);
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles with no beat on any channel; bail out when stuck.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stall per beat, plus a long hold-off on request.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk iff !rst);
    forever begin
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_results = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff out_valid);
    end
  end

  // Compare each result beat against the oldest expectation.
  always @(posedge clk) begin
    frame_report_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        e = expected_reports.pop_front();
        if (frame_index !== e.frame) begin
          $error("frame_index exp %0d got %0d", e.frame, frame_index); error_count++;
        end
        if (next_frame_index !== e.next) begin
          $error("next_frame_index exp %0d got %0d", e.next, next_frame_index);
          error_count++;
        end
        if (blend_ratio !== e.ratio) begin
          $error("blend_ratio exp %0d got %0d", e.ratio, blend_ratio); error_count++;
        end
        if (fading !== e.fade) begin
          $error("fading exp %0b got %0b", e.fade, fading); error_count++;
        end
        if (finished !== e.done) begin
          $error("finished exp %0b got %0b", e.done, finished); error_count++;
        end
      end
    end
  end

  // Send one beat after a random gap; predict on acceptance. Valid stays up
  // after the beat; the block stalls until idle, and the next call or the
  // drain drops it.
  task automatic send_item(play_item_t it, bit no_gap = 0);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    command          <= it.cmd;
    delta_time       <= it.delta;
    speed            <= it.spd;
    fade_duration    <= it.fade_dur;
    clip_start_time  <= it.start;
    clip_length      <= it.length;
    clip_first_frame <= it.first;
    clip_last_frame  <= it.last;
    repeat_flag      <= it.rep;
    reverse_flag     <= it.rev;
    seek_frame       <= it.seek;
    @(posedge clk iff !in_stall);
    expected_reports.push_back(predict_frame_report(it));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers are only touched once the block has gone quiet.
  task automatic write_reg(reg_idx_t idx, logic [7:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FPS) m_fps = data;
    else m_play_en = data[0];
  endtask

  function automatic play_item_t tick_item(logic [15:0] d);
    play_item_t it;
    it = '{default: '0};
    it.cmd   = CMD_TICK;
    it.delta = d;
    return it;
  endfunction

  // Random play beat; mostly modest clips so ticks actually wrap and clamp.
  function automatic play_item_t random_play();
    play_item_t it;
    it = '{default: '0};
    it.cmd      = CMD_PLAY;
    it.spd      = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
    it.fade_dur = ($urandom_range(0, 4) == 0) ? 32'd0
                : ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 200000);
    it.start    = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1 << 20);
    it.length   = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1 << 19);
    it.first    = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 500));
    it.last     = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 800));
    it.rep      = 1'($urandom_range(0, 1));
    it.rev      = 1'($urandom_range(0, 1));
    it.seek     = 20'($urandom);
    it.delta    = 16'($urandom);
    return it;
  endfunction

  function automatic play_item_t random_item();
    play_item_t it;
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) begin
      it = tick_item(16'($urandom));
      it.spd = 16'($urandom);
    end else if (sel < 16) it = random_play();
    else if (sel < 19) begin
      it = random_play();
      it.cmd  = CMD_SEEK;
      it.seek = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 600));
    end else begin
      it = random_play();
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  task automatic test_directed();
    play_item_t it;
    send_item(tick_item(16'hFFFF));
    send_item(tick_item(16'h0000));
    // Zero fade duration completes on the next tick.
    it = random_play();
    it.fade_dur = 0; it.start = 32'h0001_0000; it.length = 32'h0004_0000;
    it.first = 0; it.last = 20'hFFFFF; it.rep = 0; it.rev = 0; it.spd = 16'hFFFF;
    send_item(it);
    send_item(tick_item(16'h1000));
    send_item(tick_item(16'hFFFF));
    send_item(tick_item(16'hFFFF));
    // Seek past the end, then to the start.
    it.cmd = CMD_SEEK; it.seek = 20'hFFFFF;
    send_item(it);
    send_item(tick_item(16'h0000));
    it.seek = 0;
    send_item(it);
    send_item(tick_item(16'h0000));
    // Reverse, repeating clip with a real fade, then a second play of it.
    it = random_play();
    it.fade_dur = 32'h0000_8000; it.rev = 1; it.rep = 1;
    it.start = 32'hFFFF_FFFF; it.length = 32'hFFFF_FFFF; it.first = 20'hFFFFF;
    send_item(it);
    send_item(tick_item(16'h2000));
    it.length = 32'h0002_0000; it.start = 0; it.first = 3; it.last = 20;
    send_item(it);
    repeat (6) send_item(tick_item(16'h4000));
    it.cmd = CMD_NONE;
    send_item(it);
    send_item(tick_item(16'h8000));
  endtask

  task automatic test_register_settings();
    write_reg(REG_FPS, 8'd0);
    repeat (6) send_item(random_item());
    write_reg(REG_FPS, 8'd255);
    repeat (6) send_item(random_item());
    write_reg(REG_PLAY, 8'd0);
    // Paused: a zero-length fade must still finish.
    begin
      play_item_t it;
      it = random_play();
      it.fade_dur = 0;
      send_item(it);
    end
    repeat (6) send_item(random_item());
    write_reg(REG_PLAY, 8'd1);
    write_reg(REG_FPS, 8'd1);
    repeat (6) send_item(random_item());
    write_reg(REG_FPS, 8'd240);
  endtask

  task automatic test_random_mix();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      repeat (190) send_item(random_item());
      write_reg(REG_FPS, 8'($urandom_range(0, 255)));
      if (phase == 3) write_reg(REG_PLAY, 8'd0);
      if (phase == 4) write_reg(REG_PLAY, 8'd1);
    end
  endtask

  // Hold the result side off while input keeps coming, so the block backs up.
  task automatic test_backpressure();
    hold_cycles  = 400;
    hold_results = 1'b1;
    repeat (20) send_item(random_item(), 1);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; command = CMD_TICK; delta_time = '0; speed = '0;
    fade_duration = '0; clip_start_time = '0; clip_length = '0;
    clip_first_frame = '0; clip_last_frame = '0; repeat_flag = 1'b0;
    reverse_flag = 1'b0; seek_frame = '0;
    cfg_valid = 1'b0; cfg_index = REG_FPS; cfg_data = '0;
    error_count = 0; idle_cycles = 0; hold_results = 1'b0; hold_cycles = 0;
    predict_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_register_settings();
    test_backpressure();
    test_random_mix();
    drain();

    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
